// ===== hdl/click_drag_gesture_classifier_top_defines.svh =====
// Assertion macros shared by the click and drag gesture classifier modules.
`ifndef CLICK_DRAG_GESTURE_CLASSIFIER_TOP_DEFINES_SVH
`define CLICK_DRAG_GESTURE_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and off during rst.
`define CDGC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and off during rst.
`define CDGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cdgc_pkg.sv =====
// Types, codes and constants for the click and drag gesture classifier.
package cdgc_pkg;

  // Event codes on the input word.
  localparam logic [1:0] OP_MOVE  = 2'd0;
  localparam logic [1:0] OP_DOWN  = 2'd1;
  localparam logic [1:0] OP_UP    = 2'd2;
  localparam logic [1:0] OP_WHEEL = 2'd3;

  // Result kinds on the output word.
  localparam logic [1:0] KIND_WHEEL = 2'd0;
  localparam logic [1:0] KIND_DOWN  = 2'd1;
  localparam logic [1:0] KIND_DRAG  = 2'd2;
  localparam logic [1:0] KIND_MULTI = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_DCT    = 2'd1;
  localparam logic [1:0] REG_DX     = 2'd2;
  localparam logic [1:0] REG_DY     = 2'd3;

  // Reset values of the registers.
  localparam logic        ENABLE_RST = 1'b1;
  localparam logic [15:0] DCT_RST    = 16'd500;
  localparam logic [7:0]  DX_RST     = 8'd4;
  localparam logic [7:0]  DY_RST     = 8'd4;

  // Gesture thresholds.
  localparam int unsigned DRAG_MIN    = 15;
  localparam logic [8:0]  DRAG_MIN_SQ = 9'(DRAG_MIN * DRAG_MIN);
  localparam logic [31:0] MULTI_MIN   = 32'd2;
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

  // Command queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QA_W   = $clog2(QDEPTH);
  localparam int unsigned QC_W   = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        event_time;
    logic signed [15:0] wheel_amount;
    logic               synthetic;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_wheel;
    logic [31:0]        out_count;
    logic [31:0]        sequence_res;
  } out_t;

  // One classified command as it waits in the queue.
  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        t;
    logic signed [15:0] wheel;
  } cmd_t;

  // Configuration seen by the back part.
  typedef struct packed {
    logic        enable;
    logic [15:0] dct;
    logic [7:0]  dx;
    logic [7:0]  dy;
  } cfg_t;

  // Magnitude of a 17-bit signed difference.
  function automatic logic [16:0] mag17(input logic [16:0] d);
    mag17 = d[16] ? 17'(-d) : d;
  endfunction

endpackage

// ===== hdl/cdgc_front.sv =====
// Front part: accepts pointer words, drops ignored ones, queues commands.
module cdgc_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  cdgc_pkg::in_t    in_word,
  input  logic             q_full,
  output logic             push,
  output cdgc_pkg::cmd_t   push_cmd
);

  // A word is taken whenever the queue has room.
  assign in_ready = !q_full;

  // Synthetic events and moves have no effect, so they never enter the queue.
  always_comb begin
    push = in_valid && !q_full && !in_word.synthetic && (in_word.op != cdgc_pkg::OP_MOVE);
    push_cmd.op    = in_word.op;
    push_cmd.x     = in_word.pos_x;
    push_cmd.y     = in_word.pos_y;
    push_cmd.t     = in_word.event_time;
    push_cmd.wheel = in_word.wheel_amount;
  end

endmodule

// ===== hdl/cdgc_queue.sv =====
// Short command queue between the front and back parts.
`include "click_drag_gesture_classifier_top_defines.svh"

module cdgc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cdgc_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output cdgc_pkg::cmd_t head
);

  cdgc_pkg::cmd_t                  slots [cdgc_pkg::QDEPTH];
  logic [cdgc_pkg::QA_W-1:0]       wptr;
  logic [cdgc_pkg::QA_W-1:0]       rptr;
  logic [cdgc_pkg::QC_W-1:0]       count;

  assign full      = (count == cdgc_pkg::QC_W'(cdgc_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == cdgc_pkg::QA_W'(cdgc_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == cdgc_pkg::QA_W'(cdgc_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + cdgc_pkg::QC_W'(1);
      end else if (pop && !push) begin
        count <= count - cdgc_pkg::QC_W'(1);
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

  `CDGC_ASSERT_NOW(a_no_push_full, push, !full, "command pushed into a full queue")
  `CDGC_ASSERT_NOW(a_no_pop_empty, pop, not_empty, "command popped from an empty queue")

endmodule

// ===== hdl/cdgc_back.sv =====
// Back part: runs the click and drag state and holds the result word.
`include "click_drag_gesture_classifier_top_defines.svh"

module cdgc_back (
  input  logic            clk,
  input  logic            rst,
  input  cdgc_pkg::cfg_t  cfg,
  input  logic            q_not_empty,
  input  cdgc_pkg::cmd_t  head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output cdgc_pkg::out_t  out_word
);

  logic [31:0]        last_click_time;
  logic signed [15:0] last_click_x;
  logic signed [15:0] last_click_y;
  logic [31:0]        click_count;
  logic [31:0]        click_sequence;
  logic               button_held;
  logic signed [15:0] press_x;
  logic signed [15:0] press_y;

  logic [31:0]        click_count_next;
  logic [31:0]        click_sequence_next;
  logic               button_held_next;
  logic               down_upd;
  logic               emit;
  cdgc_pkg::out_t     res;

  logic [31:0]        gap;
  logic [16:0]        adx;
  logic [16:0]        ady;
  logic [16:0]        pdx;
  logic [16:0]        pdy;
  logic [7:0]         sqx;
  logic [7:0]         sqy;
  logic               near;
  logic               drag;

  // The head command moves on when the result slot is free or being emptied.
  assign pop = q_not_empty && (!out_valid || out_ready);

  // Multi-click window against the last click, and press-to-release distance.
  always_comb begin
    gap  = head.t - last_click_time;
    adx  = cdgc_pkg::mag17(17'({head.x[15], head.x} - {last_click_x[15], last_click_x}));
    ady  = cdgc_pkg::mag17(17'({head.y[15], head.y} - {last_click_y[15], last_click_y}));
    near = (gap <= {16'd0, cfg.dct}) && (adx <= {9'd0, cfg.dx}) && (ady <= {9'd0, cfg.dy});
    pdx  = cdgc_pkg::mag17(17'({head.x[15], head.x} - {press_x[15], press_x}));
    pdy  = cdgc_pkg::mag17(17'({head.y[15], head.y} - {press_y[15], press_y}));
    // Either leg at the threshold is a drag; otherwise both are below 16.
    sqx  = {4'd0, pdx[3:0]} * {4'd0, pdx[3:0]};
    sqy  = {4'd0, pdy[3:0]} * {4'd0, pdy[3:0]};
    drag = (pdx >= 17'(cdgc_pkg::DRAG_MIN)) || (pdy >= 17'(cdgc_pkg::DRAG_MIN)) ||
           ((9'(sqx) + 9'(sqy)) >= cdgc_pkg::DRAG_MIN_SQ);
  end

  // Per-command state update and result word.
  always_comb begin
    click_count_next    = click_count;
    click_sequence_next = click_sequence;
    button_held_next    = button_held;
    down_upd            = 1'b0;
    emit                = 1'b0;
    res.kind            = cdgc_pkg::KIND_WHEEL;
    res.out_x           = head.x;
    res.out_y           = head.y;
    res.out_wheel       = '0;
    res.sequence_res    = '0;
    case (head.op)
      cdgc_pkg::OP_WHEEL: begin
        emit          = 1'b1;
        res.out_wheel = head.wheel;
      end
      cdgc_pkg::OP_DOWN: begin
        emit     = 1'b1;
        res.kind = cdgc_pkg::KIND_DOWN;
        if (cfg.enable) begin
          down_upd = 1'b1;
          if (!near) begin
            click_count_next = 32'd1;
          end else if (click_count != cdgc_pkg::COUNT_MAX) begin
            click_count_next = click_count + 32'd1;
          end
          click_sequence_next = click_sequence + 32'd1;
          button_held_next    = 1'b1;
        end
      end
      cdgc_pkg::OP_UP: begin
        if (cfg.enable && button_held) begin
          button_held_next = 1'b0;
          if (drag) begin
            emit     = 1'b1;
            res.kind = cdgc_pkg::KIND_DRAG;
          end else if (click_count >= cdgc_pkg::MULTI_MIN) begin
            emit                = 1'b1;
            res.kind            = cdgc_pkg::KIND_MULTI;
            click_sequence_next = click_sequence + 32'd1;
            res.sequence_res    = click_sequence + 32'd1;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    res.out_count = click_count_next;
  end

  // Control state and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      click_count    <= '0;
      click_sequence <= '0;
      button_held    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        click_count    <= click_count_next;
        click_sequence <= click_sequence_next;
        button_held    <= button_held_next;
        out_valid      <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Click position history; reset to zero since the window check reads it.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_click_time <= '0;
      last_click_x    <= '0;
      last_click_y    <= '0;
      press_x         <= '0;
      press_y         <= '0;
    end else if (pop && down_upd) begin
      last_click_time <= head.t;
      last_click_x    <= head.x;
      last_click_y    <= head.y;
      press_x         <= head.x;
      press_y         <= head.y;
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_word <= res;
    end
  end

  `CDGC_ASSERT_NOW(a_pop_slot_free, pop, !out_valid || out_ready, "command popped over a held word")
  `CDGC_ASSERT_NEXT(a_down_notice, pop && head.op == cdgc_pkg::OP_DOWN, out_valid && out_word.kind == cdgc_pkg::KIND_DOWN, "left down gave no down notice")

endmodule

// ===== hdl/click_drag_gesture_classifier_top.sv =====
// Click and drag gesture classifier: top level with register port and channel wiring.
// Takes one pointer word per cycle while the queue has room and gives at most one
// result word per event. An accepted word goes into the queue and is then
// registered in the result register; throughput is one word per cycle while
// out_ready is high, set by the back part. A two-entry command queue sits between
// the front and back parts, so in_ready drops only when that queue is full. Moves
// and synthetic events are accepted and give no result. Registers sit at byte
// addresses 0 (enable), 4 (double-click time), 8 (dx) and 12 (dy).
module click_drag_gesture_classifier_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cdgc_pkg::in_t   in_word,
  output logic            out_valid,
  input  logic            out_ready,
  output cdgc_pkg::out_t  out_word,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  cdgc_pkg::cfg_t  cfg;
  cdgc_pkg::cmd_t  push_cmd;
  cdgc_pkg::cmd_t  head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_not_empty;
  logic [1:0]      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  // Configuration registers, written in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= cdgc_pkg::ENABLE_RST;
      cfg.dct    <= cdgc_pkg::DCT_RST;
      cfg.dx     <= cdgc_pkg::DX_RST;
      cfg.dy     <= cdgc_pkg::DY_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        cdgc_pkg::REG_ENABLE: cfg.enable <= pwdata[0];
        cdgc_pkg::REG_DCT:    cfg.dct    <= pwdata[15:0];
        cdgc_pkg::REG_DX:     cfg.dx     <= pwdata[7:0];
        cdgc_pkg::REG_DY:     cfg.dy     <= pwdata[7:0];
        default: begin
          cfg.enable <= cfg.enable;
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      cdgc_pkg::REG_ENABLE: prdata = {31'd0, cfg.enable};
      cdgc_pkg::REG_DCT:    prdata = {16'd0, cfg.dct};
      cdgc_pkg::REG_DX:     prdata = {24'd0, cfg.dx};
      cdgc_pkg::REG_DY:     prdata = {24'd0, cfg.dy};
      default:              prdata = '0;
    endcase
  end

  // Front part: acceptance and filtering.
  cdgc_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Command queue.
  cdgc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  // Back part: click state and result register.
  cdgc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word)
  );

endmodule
